// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FSA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define FSA_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define FSA_ASSERT(lbl, clk, rst, prop, msg)

`define FSA_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ----- hw/rtl/fsa_pkg.sv -----
package fsa_pkg;

  localparam int SLOTS    = 1024;
  localparam int DEPTH    = SLOTS + 1;
  localparam int SLOT_W   = $clog2(DEPTH);
  localparam int LINK_W   = $clog2(SLOTS + 3);
  localparam int USED_W   = $clog2(SLOTS + 1);
  localparam int ESIZE_W  = 16;
  localparam int OFFSET_W = 26;
  localparam int OFF_IN_W = 32;
  localparam int DVD_W    = OFF_IN_W - 1;
  localparam int PROD_W   = ESIZE_W + SLOT_W;

  localparam logic [LINK_W-1:0] END_MARK   = LINK_W'(SLOTS + 1);
  localparam logic [LINK_W-1:0] ALLOC_MARK = LINK_W'(SLOTS + 2);

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_EMPTY       = 2'd1;
  localparam logic [1:0] ST_NOT_IN_POOL = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC   = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

// ----- hw/rtl/fsa_ram.sv -----
module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fsa_div.sv -----
module fsa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fsa_pkg::DVD_W-1:0]    dividend,
  input  logic [fsa_pkg::ESIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [fsa_pkg::DVD_W-1:0]    quotient
);

  import fsa_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [ESIZE_W-1:0] rem;
  logic [ESIZE_W-1:0] dsr;
  logic [DVD_W-1:0]   work;
  logic [ESIZE_W:0]   shifted;
  logic [ESIZE_W:0]   diff;
  logic               fits;

  assign shifted = {rem, work[DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(DVD_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[DVD_W-2:0], fits};
      rem  <= fits ? diff[ESIZE_W-1:0] : shifted[ESIZE_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/fixed_slot_free_list_allocator.sv -----
// Fixed-slot pool allocator with an index-linked FIFO free list.
// Request beats enter on s_axis: tuser is the opcode (0 allocate, 1 free),
// tdata the signed byte offset to free. One result beat leaves on m_axis
// for every request: tuser is the status, tdata carries the granted offset
// and the number of slots in use after the operation.
// The cfg channel writes entry_size (bytes per slot); write it only while
// the block is idle. cfg_ready is always high.
// Requests are handled one at a time; the next request is taken the cycle
// after a result beat is loaded. An allocate reads the link entry at the
// head, marks it allocated and moves the head on; an allocate on an empty
// pool and a free with a negative offset or a zero entry size go straight
// to the result. A free runs a 31-step restoring divider (one quotient bit
// per cycle), then a read on the link memory and, when the slot is
// allocated, two writes; an index beyond the pool ends after the divider.
// The link memory has one port for reads and one for writes, registered read.
// After reset a clearing pass rebuilds the link memory; no request is
// taken during it, configuration writes are.
// When m_axis stalls, the block still takes the next request and works on
// it; its result waits until the held beat is taken.
module fixed_slot_free_list_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // free_offset
  input  logic                           s_axis_tuser,  // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // alloc_offset, used_count, zero pad
  output logic [1:0]                     m_axis_tuser,  // status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fsa_pkg::ESIZE_W-1:0]    cfg_data
);

  import fsa_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ARD  = 3'd2;
  localparam logic [2:0] S_FDIV = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FWR  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]          state;
  logic [ESIZE_W-1:0]  entry_size;
  logic [SLOT_W-1:0]   head;
  logic [SLOT_W-1:0]   tail;
  logic [USED_W-1:0]   used;
  logic [SLOT_W-1:0]   ctr;
  logic [SLOT_W-1:0]   slot;
  logic [1:0]          res_status;
  logic [OFFSET_W-1:0] res_offset;

  logic [OFFSET_W-1:0] out_offset;
  logic [USED_W-1:0]   out_used;
  logic [1:0]          out_status;

  logic                we;
  logic [SLOT_W-1:0]   waddr;
  logic [LINK_W-1:0]   wdata;
  logic [SLOT_W-1:0]   raddr;
  logic [LINK_W-1:0]   rdata;

  logic                div_start;
  logic                div_done;
  logic [DVD_W-1:0]    div_q;

  logic                accept;
  logic                pool_empty;
  logic                bad_free;
  logic [PROD_W-1:0]   prod;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pool_empty    = (head == tail) || (head > SLOT_W'(SLOTS));
  assign bad_free      = s_axis_tdata[OFF_IN_W-1] || (entry_size == '0);
  assign div_start     = accept && (s_axis_tuser == OP_FREE) && !bad_free;
  assign prod          = PROD_W'(entry_size) * PROD_W'(head);

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {3'b000, out_used, out_offset};

  fsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_axis_tdata[DVD_W-1:0]),
    .divisor  (entry_size),
    .done     (div_done),
    .quotient (div_q)
  );

  fsa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (DEPTH)
  ) u_link (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = head;
    wdata = ALLOC_MARK;
    raddr = head;
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = ctr;
        wdata = (ctr == SLOT_W'(SLOTS)) ? END_MARK : LINK_W'(ctr) + 1'b1;
      end
      S_ARD: begin
        we    = 1'b1;
        waddr = head;
        wdata = ALLOC_MARK;
      end
      S_FDIV: begin
        raddr = div_q[SLOT_W-1:0];
      end
      S_FRD: begin
        we    = (rdata == ALLOC_MARK) && (tail <= SLOT_W'(SLOTS));
        waddr = tail;
        wdata = LINK_W'(slot);
      end
      S_FWR: begin
        we    = 1'b1;
        waddr = slot;
        wdata = END_MARK;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      entry_size <= ESIZE_W'(64);
      head       <= '0;
      tail       <= SLOT_W'(SLOTS);
      used       <= '0;
      ctr        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        entry_size <= cfg_data;
      end
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          ctr <= ctr + 1'b1;
          if (ctr == SLOT_W'(SLOTS)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_offset <= '0;
            if (s_axis_tuser == OP_ALLOC) begin
              if (pool_empty) begin
                res_status <= ST_EMPTY;
                state      <= S_OUT;
              end else begin
                state <= S_ARD;
              end
            end else if (bad_free) begin
              res_status <= ST_NOT_IN_POOL;
              state      <= S_OUT;
            end else begin
              state <= S_FDIV;
            end
          end
        end
        S_ARD: begin
          head       <= rdata[SLOT_W-1:0];
          used       <= used + 1'b1;
          res_offset <= prod[OFFSET_W-1:0];
          res_status <= ST_OK;
          state      <= S_OUT;
        end
        S_FDIV: begin
          if (div_done) begin
            slot <= div_q[SLOT_W-1:0];
            if (div_q > DVD_W'(SLOTS)) begin
              res_status <= ST_NOT_IN_POOL;
              state      <= S_OUT;
            end else begin
              state <= S_FRD;
            end
          end
        end
        S_FRD: begin
          if (rdata != ALLOC_MARK) begin
            res_status <= ST_NOT_ALLOC;
            state      <= S_OUT;
          end else begin
            state <= S_FWR;
          end
        end
        S_FWR: begin
          tail       <= slot;
          if (used != '0) begin
            used <= used - 1'b1;
          end
          res_status <= ST_OK;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      out_status <= res_status;
      out_offset <= res_offset;
      out_used   <= used;
    end
  end

`include "assert_macros.svh"

  `FSA_NEVER(a_used_range, clk, rst, used > USED_W'(SLOTS), "slots in use beyond pool")
  `FSA_NEVER(a_tail_range, clk, rst, tail > SLOT_W'(SLOTS), "free tail beyond pool")
  `FSA_ASSERT(a_div_owner, clk, rst, div_done |-> state == S_FDIV, "divider done outside free")
  `FSA_ASSERT(a_offset_ok, clk, rst,
    (m_axis_tvalid && m_axis_tdata[OFFSET_W-1:0] != '0) |-> m_axis_tuser == ST_OK,
    "offset on a failed beat")

endmodule
